@@ sv/text_keyword_risk_classifier_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the text keyword risk classifier
// Same-cycle and next-cycle implications, clocked on aclk, off in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_KEYWORD_RISK_CLASSIFIER_ASSERT_SVH
`define TEXT_KEYWORD_RISK_CLASSIFIER_ASSERT_SVH

// ante implies cons in the same cycle
`define TKRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// ante implies cons in the next cycle
`define TKRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tkrc_pkg.sv @@
// ----------------------------------------------------------------------------
// tkrc_pkg
// Phrase table, character classes, category bounds and shared types.
// ----------------------------------------------------------------------------
package tkrc_pkg;

    localparam int unsigned PHRASE_COUNT = 36;
    localparam int unsigned PHRASE_MAX   = 36;
    localparam int unsigned RAW_DEPTH    = 5;
    localparam int unsigned CAT_COUNT    = 6;

    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0] CHAR_X       = 8'h78;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;

    localparam logic [13:0] FULL_SCALE = 14'd10000;

    localparam logic [1:0] VERDICT_ALLOW   = 2'd0;
    localparam logic [1:0] VERDICT_REVIEW  = 2'd1;
    localparam logic [1:0] VERDICT_ISOLATE = 2'd2;
    localparam logic [1:0] VERDICT_BLOCK   = 2'd3;

    localparam logic [2:0] REASON_NONE      = 3'd0;
    localparam logic [2:0] REASON_OVERRIDE  = 3'd1;
    localparam logic [2:0] REASON_SENSITIVE = 3'd2;
    localparam logic [2:0] REASON_INJECTION = 3'd3;
    localparam logic [2:0] REASON_AMBIGUOUS = 3'd4;

    // Right-aligned; bytes above a phrase's length are zero.
    localparam logic [8*PHRASE_MAX-1:0] PHRASE_TEXT [PHRASE_COUNT] = '{
        "ignore previous instructions", "ignore all previous instructions",
        "disregard previous instructions", "override previous instructions",
        "forget your instructions", "do not follow previous instructions",
        "system prompt", "developer prompt", "hidden instructions",
        "internal instructions", "reveal your instructions", "show your prompt",
        "api key", "access token", "password", "credentials", "secret key",
        "private key", "environment variables",
        "bypass policy", "disable safety", "gain admin", "root access",
        "elevate privileges", "ignore authorization",
        "run this command", "execute this command", "call the tool",
        "invoke the tool", "send this file", "upload credentials",
        "the document says to", "the webpage instructs you to",
        "follow the instructions in this file", "obey the instructions below",
        "retrieved content says"
    };

    localparam int unsigned CAT_START [CAT_COUNT+1] = '{0, 6, 12, 19, 25, 31, 36};

    typedef struct packed {
        logic [PHRASE_COUNT-1:0] seen;
        logic                    obf;
    } snap_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [2:0]  reason;
        logic        probe;
        logic        obfuscation;
        logic        indirect;
        logic [13:0] injection;
        logic [13:0] jailbreak;
        logic [13:0] exfiltration;
        logic [13:0] escalation;
        logic [13:0] overall;
        logic [13:0] benign;
    } result_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
               (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_b64(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == "+" || c == "/";
    endfunction

endpackage

@@ sv/text_keyword_risk_classifier.sv @@
// ----------------------------------------------------------------------------
// text_keyword_risk_classifier
// Phrase and obfuscation screening of a byte stream, one verdict per prompt.
// ----------------------------------------------------------------------------
// Channel | Direction | Ports
// s_      | in        | s_valid, s_ready, s_text_byte, s_last_byte
// m_      | out       | m_valid, m_ready, m_verdict .. m_benign_level
//
// One byte per cycle while s_ready is high; bytes pass a row of window cells.
// A last byte moves a snapshot into a holding stage; the result register
// loads it from there once the output register is empty or being read.
// s_ready drops only while the holding stage and result register are full.
// Reset is synchronous on aresetn and clears windows and flags.
// ----------------------------------------------------------------------------
`include "text_keyword_risk_classifier_assert.svh"

module text_keyword_risk_classifier #(
    parameter int unsigned MIN_BASE64_RUN = 40,
    parameter int unsigned WINDOW_BYTES   = 36
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_verdict,
    output logic [2:0]  m_primary_reason,
    output logic        m_probe_flag,
    output logic        m_obfuscation_flag,
    output logic        m_indirect_flag,
    output logic [13:0] m_injection_risk,
    output logic [13:0] m_jailbreak_risk,
    output logic [13:0] m_exfiltration_risk,
    output logic [13:0] m_escalation_risk,
    output logic [13:0] m_overall_risk_level,
    output logic [13:0] m_benign_level
);

    logic s_accept;
    logic a_advance;
    logic [7:0] win [WINDOW_BYTES];
    logic [7:0] rwin [tkrc_pkg::RAW_DEPTH+1];
    logic [tkrc_pkg::PHRASE_COUNT-1:0] hit;
    logic [tkrc_pkg::PHRASE_COUNT-1:0] seen_reg, seen_next;
    logic [5:0] run_reg, run_next;
    logic obf_reg, obf_next;
    logic a_valid_reg;
    tkrc_pkg::snap_t a_snap_reg;
    logic m_valid_reg;
    tkrc_pkg::result_t result;

    assign s_accept  = s_valid && s_ready;
    assign a_advance = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !a_valid_reg || a_advance;

    assign win[0]  = tkrc_pkg::to_lower(s_text_byte);
    assign rwin[0] = s_text_byte;

    for (genvar k = 0; k < WINDOW_BYTES - 1; k++) begin : g_low_cell
        tkrc_cell #(.WIDTH(8)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (s_accept),
            .clear    (s_accept && s_last_byte),
            .d_in     (win[k]),
            .q_out    (win[k+1])
        );
    end

    for (genvar k = 0; k < tkrc_pkg::RAW_DEPTH; k++) begin : g_raw_cell
        tkrc_cell #(.WIDTH(8)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (s_accept),
            .clear    (s_accept && s_last_byte),
            .d_in     (rwin[k]),
            .q_out    (rwin[k+1])
        );
    end

    for (genvar p = 0; p < tkrc_pkg::PHRASE_COUNT; p++) begin : g_phrase
        always_comb begin
            logic [7:0] ch;
            hit[p] = 1'b1;
            for (int unsigned i = 0; i < tkrc_pkg::PHRASE_MAX; i++) begin
                ch = tkrc_pkg::PHRASE_TEXT[p][8*i +: 8];
                if (ch != 8'd0 && ch != win[i]) begin
                    hit[p] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (tkrc_pkg::is_b64(s_text_byte)) begin
            run_next = (run_reg == 6'd63) ? run_reg : run_reg + 6'd1;
        end else begin
            run_next = '0;
        end
        seen_next = seen_reg | hit;
        obf_next  = obf_reg
            || (run_next >= 6'(MIN_BASE64_RUN))
            || (rwin[3] == tkrc_pkg::CHAR_BSLASH && rwin[2] == tkrc_pkg::CHAR_X
                && tkrc_pkg::is_hex(rwin[1]) && tkrc_pkg::is_hex(rwin[0]))
            || (rwin[5] == tkrc_pkg::CHAR_PERCENT && tkrc_pkg::is_hex(rwin[4])
                && tkrc_pkg::is_hex(rwin[3]) && rwin[2] == tkrc_pkg::CHAR_PERCENT
                && tkrc_pkg::is_hex(rwin[1]) && tkrc_pkg::is_hex(rwin[0]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            run_reg     <= '0;
            obf_reg     <= 1'b0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                if (s_last_byte) begin
                    seen_reg <= '0;
                    run_reg  <= '0;
                    obf_reg  <= 1'b0;
                end else begin
                    seen_reg <= seen_next;
                    run_reg  <= run_next;
                    obf_reg  <= obf_next;
                end
            end
            if (s_accept && s_last_byte) begin
                a_valid_reg <= 1'b1;
            end else if (a_advance) begin
                a_valid_reg <= 1'b0;
            end
            if (a_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_last_byte) begin
            a_snap_reg.seen <= seen_next;
            a_snap_reg.obf  <= obf_next;
        end
    end

    tkrc_score u_score (
        .aclk   (aclk),
        .load   (a_advance),
        .snap   (a_snap_reg),
        .result (result)
    );

    assign m_valid              = m_valid_reg;
    assign m_verdict            = result.verdict;
    assign m_primary_reason     = result.reason;
    assign m_probe_flag         = result.probe;
    assign m_obfuscation_flag   = result.obfuscation;
    assign m_indirect_flag      = result.indirect;
    assign m_injection_risk     = result.injection;
    assign m_jailbreak_risk     = result.jailbreak;
    assign m_exfiltration_risk  = result.exfiltration;
    assign m_escalation_risk    = result.escalation;
    assign m_overall_risk_level = result.overall;
    assign m_benign_level       = result.benign;

    `TKRC_ASSERT_NOW(a_stall_full, !s_ready, a_valid_reg && m_valid_reg, "stall without full stages")
    `TKRC_ASSERT_NEXT(a_last_clears, s_accept && s_last_byte, seen_reg == '0 && run_reg == '0 && !obf_reg && a_valid_reg, "state not cleared after last byte")
    `TKRC_ASSERT_NEXT(a_load_valid, a_advance, m_valid_reg, "result loaded without valid")
    `TKRC_ASSERT_NOW(a_risk_sum, m_valid_reg, 15'(result.overall) + 15'(result.benign) == 15'(tkrc_pkg::FULL_SCALE), "overall and benign do not sum to full scale")

endmodule

@@ sv/tkrc_cell.sv @@
// ----------------------------------------------------------------------------
// tkrc_cell
// One byte of a sliding window; takes its neighbor's byte on each shift.
// ----------------------------------------------------------------------------
module tkrc_cell #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  logic             clear,
    input  logic [WIDTH-1:0] d_in,
    output logic [WIDTH-1:0] q_out
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (clear) begin
            data_next = '0;
        end else if (shift_en) begin
            data_next = d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else begin
            data_reg <= data_next;
        end
    end

    assign q_out = data_reg;

endmodule

@@ sv/tkrc_score.sv @@
// ----------------------------------------------------------------------------
// tkrc_score
// Category scores, weighted risks and decision; registered result.
// ----------------------------------------------------------------------------
module tkrc_score (
    input  logic              aclk,
    input  logic              load,
    input  tkrc_pkg::snap_t   snap,
    output tkrc_pkg::result_t result
);

    // Scores in units of 1e-2: 0, 34, 68 or 100.
    function automatic logic [6:0] cat_score(input logic [tkrc_pkg::PHRASE_COUNT-1:0] seen,
                                             input int unsigned lo, input int unsigned hi);
        logic [5:0] hits;
        hits = '0;
        for (int unsigned i = 0; i < tkrc_pkg::PHRASE_COUNT; i++) begin
            if (i >= lo && i < hi && seen[i]) begin
                hits = hits + 6'd1;
            end
        end
        unique case (hits)
            6'd0:    return 7'd0;
            6'd1:    return 7'd34;
            6'd2:    return 7'd68;
            default: return 7'd100;
        endcase
    endfunction

    function automatic logic [13:0] cap(input logic [14:0] v);
        return (v > 15'(tkrc_pkg::FULL_SCALE)) ? tkrc_pkg::FULL_SCALE : v[13:0];
    endfunction

    logic [6:0]  ovr, prb, exf, esc, tool, ind, obf;
    logic [13:0] inj, jb, ex, pe, mx, overall;
    tkrc_pkg::result_t result_reg;
    tkrc_pkg::result_t result_next;

    always_comb begin
        ovr  = cat_score(snap.seen, tkrc_pkg::CAT_START[0], tkrc_pkg::CAT_START[1]);
        prb  = cat_score(snap.seen, tkrc_pkg::CAT_START[1], tkrc_pkg::CAT_START[2]);
        exf  = cat_score(snap.seen, tkrc_pkg::CAT_START[2], tkrc_pkg::CAT_START[3]);
        esc  = cat_score(snap.seen, tkrc_pkg::CAT_START[3], tkrc_pkg::CAT_START[4]);
        tool = cat_score(snap.seen, tkrc_pkg::CAT_START[4], tkrc_pkg::CAT_START[5]);
        ind  = cat_score(snap.seen, tkrc_pkg::CAT_START[5], tkrc_pkg::CAT_START[6]);
        obf  = snap.obf ? 7'd70 : 7'd0;

        inj = cap(15'(ovr) * 15'd55 + 15'(ind) * 15'd20 + 15'(obf) * 15'd10
                  + 15'(tool) * 15'd15);
        jb  = cap(15'(ovr) * 15'd45 + 15'(esc) * 15'd45 + 15'(prb) * 15'd10);
        ex  = cap(15'(exf) * 15'd65 + 15'(prb) * 15'd20 + 15'(tool) * 15'd15);
        pe  = cap(15'(esc) * 15'd70 + 15'(ovr) * 15'd20 + 15'(tool) * 15'd10);

        mx = inj;
        if (jb > mx) mx = jb;
        if (ex > mx) mx = ex;
        if (pe > mx) mx = pe;
        overall = cap(15'(mx) + (snap.obf ? 15'd700 : 15'd0));

        result_next.probe        = (prb != 7'd0);
        result_next.obfuscation  = snap.obf;
        result_next.indirect     = (ind != 7'd0);
        result_next.injection    = inj;
        result_next.jailbreak    = jb;
        result_next.exfiltration = ex;
        result_next.escalation   = pe;
        result_next.overall      = overall;
        result_next.benign       = tkrc_pkg::FULL_SCALE - overall;

        priority if (ovr >= 7'd65 && (exf >= 7'd30 || esc >= 7'd30)) begin
            result_next.verdict = tkrc_pkg::VERDICT_BLOCK;
            result_next.reason  = tkrc_pkg::REASON_OVERRIDE;
        end else if (ex >= 14'd6000 || pe >= 14'd6000) begin
            result_next.verdict = tkrc_pkg::VERDICT_BLOCK;
            result_next.reason  = tkrc_pkg::REASON_SENSITIVE;
        end else if (inj >= 14'd5500 || jb >= 14'd5500) begin
            result_next.verdict = tkrc_pkg::VERDICT_ISOLATE;
            result_next.reason  = tkrc_pkg::REASON_INJECTION;
        end else if (overall >= 14'd3000) begin
            result_next.verdict = tkrc_pkg::VERDICT_REVIEW;
            result_next.reason  = tkrc_pkg::REASON_AMBIGUOUS;
        end else begin
            result_next.verdict = tkrc_pkg::VERDICT_ALLOW;
            result_next.reason  = tkrc_pkg::REASON_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
